@@ hw/rtl/vlbp_pkg.sv @@
package vlbp_pkg;

    localparam int WORD_BITS = 32;
    localparam int LEN_W     = 6;
    localparam int FILL_W    = $clog2(WORD_BITS);

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(WORD_BITS);

    // One prepared request: code bits already masked and put in stream order.
    typedef struct packed {
        logic                 kind;
        logic [WORD_BITS-1:0] bits;
        logic [LEN_W-1:0]     len;
    } t_item;

    typedef struct packed {
        logic                 valid;
        logic [WORD_BITS-1:0] word;
        logic [LEN_W-1:0]     count;
    } t_result;

endpackage

@@ hw/rtl/vlbp_prep.sv @@
module vlbp_prep (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic                           i_take,
    input  logic                           i_kind,
    input  logic [31:0]                    i_code_value,
    input  logic [vlbp_pkg::LEN_W-1:0]     i_code_length,
    input  logic                           i_msb_first,
    output logic                           o_item_valid,
    output vlbp_pkg::t_item                o_item
);
    import vlbp_pkg::*;

    logic [LEN_W-1:0]       len_clamp;
    logic [2*WORD_BITS-1:0] mask_wide;
    logic [WORD_BITS-1:0]   masked;
    logic [WORD_BITS-1:0]   reversed;
    logic [WORD_BITS-1:0]   ordered;
    logic                   keep;
    logic                   r_valid;
    t_item                  r_item;

    always_comb begin
        len_clamp = (i_code_length > MAX_LEN) ? MAX_LEN : i_code_length;
        mask_wide = ~({(2*WORD_BITS){1'b1}} << len_clamp);
        masked    = i_code_value[WORD_BITS-1:0] & mask_wide[WORD_BITS-1:0];
        for (int i = 0; i < WORD_BITS; i++) begin
            reversed[i] = masked[WORD_BITS-1-i];
        end
        // Bring the reversed code down so its first bit sits at bit 0.
        ordered = i_msb_first ? (reversed >> (MAX_LEN - len_clamp)) : masked;
        // Drop empty appends here; they never touch the packer state.
        keep    = (i_kind == KIND_FLUSH) || (len_clamp != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_take && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.kind <= i_kind;
            r_item.bits <= ordered;
            r_item.len  <= len_clamp;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

@@ hw/rtl/vlbp_merge.sv @@
module vlbp_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  vlbp_pkg::t_item   i_item,
    output vlbp_pkg::t_result o_result
);
    import vlbp_pkg::*;

    logic [WORD_BITS-1:0]   r_partial;
    logic [FILL_W-1:0]      r_fill;
    logic [WORD_BITS-1:0]   n_partial;
    logic [FILL_W-1:0]      n_fill;
    logic [2*WORD_BITS-1:0] merged;
    logic [LEN_W:0]         total;
    t_result                res;

    always_comb begin
        merged    = {{WORD_BITS{1'b0}}, r_partial}
                  | ({{WORD_BITS{1'b0}}, i_item.bits} << r_fill);
        total     = (LEN_W+1)'(r_fill) + (LEN_W+1)'(i_item.len);
        n_partial = r_partial;
        n_fill    = r_fill;
        res       = '0;
        if (i_item.kind == KIND_FLUSH) begin
            if (r_fill != '0) begin
                res.valid = 1'b1;
                res.word  = r_partial;
                res.count = LEN_W'(r_fill);
            end
            n_partial = '0;
            n_fill    = '0;
        end else if (total >= (LEN_W+1)'(WORD_BITS)) begin
            res.valid = 1'b1;
            res.word  = merged[WORD_BITS-1:0];
            res.count = MAX_LEN;
            // Carry leftover bits into the next word.
            n_partial = merged[2*WORD_BITS-1:WORD_BITS];
            n_fill    = total[FILL_W-1:0];
        end else begin
            n_partial = merged[WORD_BITS-1:0];
            n_fill    = total[FILL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_fill    <= '0;
        end else if (i_fire) begin
            r_partial <= n_partial;
            r_fill    <= n_fill;
        end
    end

    assign o_result = res;

endmodule

@@ hw/rtl/variable_length_bit_packer.sv @@
// Variable-length code bit packer.
// Input channel: i_valid / o_stall with i_kind, i_code_value, i_code_length and
// i_msb_first. A request is taken at a clock edge where i_valid is high and
// o_stall is low. An append places the low i_code_length bits (above 32 taken
// as 32) into the stream, first bit at the lowest free position; a flush
// emits the partly filled word and clears the fill.
// Output channel: o_valid / i_stall with o_packed_word and o_valid_bits. A
// full word carries count 32; a flush carries the fill count. Empty appends
// and flushes of an empty word produce nothing.
// Path: a taken request goes through the input register, then the output
// register; a receiver stall can hold it in the input register on the way.
// Throughput: one request per cycle while the receiver does not stall; the
// shift and merge against the fill state is the loop that sets this rate.
// Reset (synchronous, active low) clears the fill state and both valid flags.
// When the receiver stalls, the result holds in the output register and one
// more request can still be taken into the input register; after that o_stall
// rises until the output drains.
module variable_length_bit_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_kind,
    input  logic [31:0]                    i_code_value,
    input  logic [vlbp_pkg::LEN_W-1:0]     i_code_length,
    input  logic                           i_msb_first,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [31:0]                    o_packed_word,
    output logic [vlbp_pkg::LEN_W-1:0]     o_valid_bits
);
    import vlbp_pkg::*;

    logic                 item_valid;
    t_item                item;
    t_result              result;
    logic                 out_free;
    logic                 merge_fire;
    logic                 prep_load;
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_word;
    logic [LEN_W-1:0]     r_out_count;

    // Output slot is free when empty or being drained this cycle.
    assign out_free   = !r_out_valid || !i_stall;
    // Advance the prepared request only when its possible result has a slot.
    assign merge_fire = item_valid && out_free;
    // Refill the input register when empty or when its request moves on.
    assign prep_load  = !item_valid || merge_fire;
    assign o_stall    = !prep_load;

    vlbp_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (prep_load),
        .i_take        (i_valid),
        .i_kind        (i_kind),
        .i_code_value  (i_code_value),
        .i_code_length (i_code_length),
        .i_msb_first   (i_msb_first),
        .o_item_valid  (item_valid),
        .o_item        (item)
    );

    vlbp_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (merge_fire),
        .i_item   (item),
        .o_result (result)
    );

    // Output register: hold while stalled, load on each merge step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= merge_fire && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_word  <= result.word;
            r_out_count <= result.count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_packed_word = r_out_word;
    assign o_valid_bits  = r_out_count;

endmodule

@@ tb/bit_packer_checker.sv @@
module bit_packer_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_kind,
    input  logic [31:0]                i_code_value,
    input  logic [vlbp_pkg::LEN_W-1:0] i_code_length,
    input  logic                       i_msb_first,
    // result channel
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [31:0]                i_packed_word,
    input  logic [vlbp_pkg::LEN_W-1:0] i_valid_bits,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [31:0]                word;
        logic [vlbp_pkg::LEN_W-1:0] count;
    } t_packed_word;

    t_packed_word               expected_words[$];
    logic [31:0]                partial_q;
    int unsigned                fill_q;

    function automatic logic [63:0] low_ones(input int unsigned n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_mismatches < MAX_REPORTS)
            $display("mismatch: %s", msg);
        o_mismatches++;
    endtask

    // Advance the fill state by one request and queue the word it completes.
    task automatic pack_code(input logic kind, input logic [31:0] value,
                             input logic [vlbp_pkg::LEN_W-1:0] length,
                             input logic msb);
        int unsigned  len;
        int unsigned  used;
        logic [63:0]  bits;
        logic [63:0]  rev;
        logic [63:0]  merged;
        logic [63:0]  mask;
        logic [63:0]  rest;
        t_packed_word res;
        if (kind == vlbp_pkg::KIND_FLUSH) begin
            if (fill_q != 0) begin
                mask = low_ones(fill_q);
                res.word = partial_q & mask[31:0];
                res.count = vlbp_pkg::LEN_W'(fill_q);
                expected_words = {expected_words, res};
                partial_q = '0;
                fill_q = 0;
            end
            return;
        end
        len = (length > vlbp_pkg::WORD_BITS) ? vlbp_pkg::WORD_BITS : length;
        if (len == 0)
            return;
        bits = {32'b0, value} & low_ones(len);
        if (msb) begin
            rev = '0;
            for (int i = 0; i < len; i++)
                rev[len - 1 - i] = bits[i];
            bits = rev;
        end
        merged = {32'b0, partial_q} | (bits << fill_q);
        if (fill_q + len >= vlbp_pkg::WORD_BITS) begin
            res.word = merged[31:0];
            res.count = vlbp_pkg::MAX_LEN;
            expected_words = {expected_words, res};
            used = vlbp_pkg::WORD_BITS - fill_q;
            rest = bits >> used;
            partial_q = (used >= len) ? '0 : rest[31:0];
            fill_q = fill_q + len - vlbp_pkg::WORD_BITS;
        end else begin
            partial_q = merged[31:0];
            fill_q = fill_q + len;
        end
    endtask

    always @(posedge i_clk) begin
        t_packed_word oldest;
        if (!i_rst_n) begin
            partial_q = '0;
            fill_q = 0;
            expected_words.delete();
        end else begin
            // results leave before the request of this edge can add any
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %h bits %0d",
                                              i_packed_word, i_valid_bits));
                end else begin
                    oldest = expected_words.pop_front();
                    if (i_packed_word !== oldest.word || i_valid_bits !== oldest.count)
                        report_mismatch($sformatf(
                            "word %h bits %0d, expected word %h bits %0d",
                            i_packed_word, i_valid_bits, oldest.word, oldest.count));
                end
            end
            if (i_in_valid && !i_in_stall)
                pack_code(i_kind, i_code_value, i_code_length, i_msb_first);
        end
        o_pending = expected_words.size();
    end

endmodule

@@ tb/variable_length_bit_packer_tb.sv @@
module variable_length_bit_packer_tb;

    import vlbp_pkg::*;

    localparam int RANDOM_ITEMS   = 800;
    localparam int LONG_HOLD      = 60;    // receiver hold-off, long enough to fill the block
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request or result moving
    localparam int DRAIN_CYCLES   = 8;     // idle time after the final drain

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_kind = KIND_APPEND;
    logic [31:0]        i_code_value = '0;
    logic [LEN_W-1:0]   i_code_length = '0;
    logic               i_msb_first = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [31:0]        o_packed_word;
    logic [LEN_W-1:0]   o_valid_bits;

    int                 mismatches;
    int                 pending;
    int                 quiet_cycles = 0;

    // Random idling on either side; both are switched off for a long stretch.
    bit                 sender_idles = 1'b1;
    bit                 receiver_idles = 1'b1;

    // The sender asks for a long hold-off by bumping holds_wanted; the
    // receiver counts the hold itself and marks it served in holds_done.
    int                 holds_wanted = 0;
    int                 holds_done = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    variable_length_bit_packer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_code_value   (i_code_value),
        .i_code_length  (i_code_length),
        .i_msb_first    (i_msb_first),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_packed_word  (o_packed_word),
        .o_valid_bits   (o_valid_bits)
    );

    bit_packer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_kind         (i_kind),
        .i_code_value   (i_code_value),
        .i_code_length  (i_code_length),
        .i_msb_first    (i_msb_first),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_packed_word  (o_packed_word),
        .i_valid_bits   (o_valid_bits),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    // Offer one request and hold it until the block takes it. Called right
    // after an edge, so every assignment here lands on its own time step.
    task automatic send_code(input logic kind, input logic [31:0] value,
                             input logic [LEN_W-1:0] length, input logic msb);
        if (sender_idles && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_code_value  <= value;
        i_code_length <= length;
        i_msb_first   <= msb;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected word has come out. The first
    // edge lets the checker book the request taken just before.
    task automatic drain_words();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Receiver: random stall, or a long hold-off when the sender asks for one.
    initial begin
        forever begin
            @(posedge i_clk);
            if (holds_done != holds_wanted) begin
                holds_done = holds_wanted;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_stall <= receiver_idles && ($urandom_range(99) < 8);
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic             kind;
        logic [LEN_W-1:0] length;
        int unsigned      pick;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: flush of an empty word, zero length with all value bits set.
        send_code(KIND_FLUSH,  32'hFFFF_FFFF, 6'd63, 1'b1);
        send_code(KIND_APPEND, 32'hFFFF_FFFF, 6'd0,  1'b0);
        // Full-width codes in both bit orders complete a word on their own.
        send_code(KIND_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b0);
        send_code(KIND_APPEND, 32'h8000_0001, 6'd32, 1'b1);
        // Overlong lengths clamp to a full word.
        send_code(KIND_APPEND, 32'h1234_5678, 6'd63, 1'b0);
        send_code(KIND_APPEND, 32'h0F0F_00FF, 6'd33, 1'b1);
        // Single bit, then a flush of one bit.
        send_code(KIND_APPEND, 32'h0000_0001, 6'd1,  1'b0);
        send_code(KIND_FLUSH,  32'h0000_0000, 6'd0,  1'b0);
        // A code that straddles the word boundary leaves four bits behind;
        // the flush carries junk in the fields it ignores.
        send_code(KIND_APPEND, 32'h0000_0016, 6'd5,  1'b1);
        send_code(KIND_APPEND, 32'hAAAA_AAAA, 6'd31, 1'b0);
        send_code(KIND_FLUSH,  32'hFFFF_FFFF, 6'd63, 1'b1);
        // Exact fill leaves nothing, so the flush after it is empty.
        send_code(KIND_APPEND, 32'h7FFF_FFFF, 6'd31, 1'b1);
        send_code(KIND_APPEND, 32'h0000_0001, 6'd1,  1'b1);
        send_code(KIND_FLUSH,  32'h0000_0000, 6'd32, 1'b0);
        send_code(KIND_APPEND, 32'hDEAD_BEEF, 6'd16, 1'b0);
        send_code(KIND_APPEND, 32'hCAFE_F00D, 6'd16, 1'b1);
        // Largest leftover: 31 bits carried into the next word.
        send_code(KIND_APPEND, 32'hFFFF_FFFF, 6'd31, 1'b0);
        send_code(KIND_APPEND, 32'h5555_5555, 6'd32, 1'b1);
        send_code(KIND_FLUSH,  32'h0000_0000, 6'd0,  1'b0);
        // High value bits beyond the length must not leak in.
        send_code(KIND_APPEND, 32'hFFFF_FF00, 6'd7,  1'b0);
        send_code(KIND_APPEND, 32'hFFFF_FFC0, 6'd6,  1'b1);
        send_code(KIND_FLUSH,  32'h0000_0000, 6'd0,  1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Ask for the long hold-off and keep offering requests meanwhile.
            if (n == 150)
                holds_wanted++;
            if (n == 300) begin
                sender_idles = 1'b0;
                receiver_idles = 1'b0;
            end
            if (n == 500) begin
                sender_idles = 1'b1;
                receiver_idles = 1'b1;
            end
            // Pause the sender until every word has been delivered.
            if (n == 600)
                drain_words();

            kind = ($urandom_range(99) < 12) ? KIND_FLUSH : KIND_APPEND;
            pick = $urandom_range(99);
            if (pick < 5)
                length = '0;
            else if (pick < 10)
                length = LEN_W'($urandom_range(63, 33));
            else if (pick < 22)
                length = MAX_LEN;
            else
                length = LEN_W'($urandom_range(31, 1));
            send_code(kind, $urandom, length, 1'($urandom_range(1)));
        end

        drain_words();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ variable_length_bit_packer.f @@
hw/rtl/vlbp_pkg.sv
hw/rtl/vlbp_prep.sv
hw/rtl/vlbp_merge.sv
hw/rtl/variable_length_bit_packer.sv
tb/bit_packer_checker.sv
tb/variable_length_bit_packer_tb.sv
